### sv/drt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dual reload timer
// Command codes, register byte selects, control bit positions and the
// per-timer status handed from each timer slice to the top level.
// ----------------------------------------------------------------------------
package drt_pkg;

  // Timers present and port width (one bit per timer slot)
  localparam int NUM_TIMERS  = 2;
  localparam int TIMER_SLOTS = 2;

  // Request commands
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  // Register byte within one timer's window
  typedef enum logic [1:0] {
    REG_CTL_LO = 2'd0,
    REG_CTL_HI = 2'd1,
    REG_RLD_LO = 2'd2,
    REG_RLD_HI = 2'd3
  } reg_sel_t;

  // Clock select field of the high control byte
  typedef enum logic [1:0] {
    CSL_DIV2  = 2'd0,
    CSL_DIV16 = 2'd1,
    CSL_DIV64 = 2'd2,
    CSL_EVENT = 2'd3
  } csl_t;

  // Counted edge in event mode: {MOD1, MOD0}
  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2,
    EDGE_BOTH = 2'd3
  } edge_mode_t;

  // Control low bit positions
  localparam int CTL_MOD0 = 7;
  localparam int CTL_RELD = 4;
  localparam int CTL_INTE = 3;
  localparam int CTL_UF   = 2;
  localparam int CTL_CNTE = 1;
  localparam int CTL_TRG  = 0;

  // Control high bit positions
  localparam int CTH_CSL_LO = 2;
  localparam int CTH_MOD1   = 0;

  // Prescaler terminal counts (the divide-by-64 case wraps to zero)
  localparam logic [5:0] PRE_END_DIV2  = 6'd2;
  localparam logic [5:0] PRE_END_DIV16 = 6'd16;
  localparam logic [5:0] PRE_END_DIV64 = 6'd0;

  // Status of one timer after the current request
  typedef struct packed {
    logic irq;
    logic uf_now;
  } timer_status_t;

endpackage : drt_pkg
`default_nettype wire

### sv/drt_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drt_timer: one 16-bit reload timer slice
// Holds the four register bytes, down counter, prescaler, run flag and pin
// history of one timer, and works out their next values for one request.
// ----------------------------------------------------------------------------
module drt_timer (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire drt_pkg::cmd_t          cmd,
  input  wire logic                   sel,
  input  wire drt_pkg::reg_sel_t      reg_idx,
  input  wire logic [7:0]             write_data,
  input  wire logic                   pin,
  output logic [7:0]                  rd_byte,
  output drt_pkg::timer_status_t      status
);
  import drt_pkg::*;

  logic [7:0]  ctl_lo, ctl_lo_next;
  logic [7:0]  ctl_hi, ctl_hi_next;
  logic [7:0]  rld_lo, rld_lo_next;
  logic [7:0]  rld_hi, rld_hi_next;
  logic [15:0] cnt, cnt_next;
  logic [5:0]  pre, pre_next;
  logic        run, run_next;
  logic        last, last_next;

  logic [15:0] reload;
  logic [5:0]  pre_inc;
  logic        counting;
  logic        pre_hit;
  logic        edge_hit;
  logic        dec;
  logic        uf;
  csl_t        csl;
  edge_mode_t  edge_mode;

  assign reload    = {rld_hi, rld_lo};
  assign csl       = csl_t'(ctl_hi[CTH_CSL_LO +: 2]);
  assign edge_mode = edge_mode_t'({ctl_hi[CTH_MOD1], ctl_lo[CTL_MOD0]});
  assign counting  = run & ctl_lo[CTL_CNTE];
  assign pre_inc   = pre + 6'd1;

  // Prescaler terminal count for the selected divider
  always_comb begin
    unique case (csl)
      CSL_DIV2:  pre_hit = (pre_inc == PRE_END_DIV2);
      CSL_DIV16: pre_hit = (pre_inc == PRE_END_DIV16);
      CSL_DIV64: pre_hit = (pre_inc == PRE_END_DIV64);
      default:   pre_hit = 1'b0;
    endcase
  end

  // Detect the selected pin edge against the stored level
  always_comb begin
    unique case (edge_mode)
      EDGE_RISE: edge_hit = pin & ~last;
      EDGE_FALL: edge_hit = ~pin & last;
      EDGE_BOTH: edge_hit = pin ^ last;
      default:   edge_hit = 1'b0;
    endcase
  end

  // Next state for one request
  always_comb begin
    ctl_lo_next = ctl_lo;
    ctl_hi_next = ctl_hi;
    rld_lo_next = rld_lo;
    rld_hi_next = rld_hi;
    cnt_next    = cnt;
    pre_next    = pre;
    run_next    = run;
    last_next   = last;
    dec         = 1'b0;
    uf          = 1'b0;

    unique case (cmd)
      CMD_READ: begin
      end
      CMD_WRITE: begin
        if (sel) begin
          unique case (reg_idx)
            REG_CTL_LO: begin
              // UF only clears on a written 0; TRG never sticks
              ctl_lo_next = write_data;
              ctl_lo_next[CTL_TRG] = 1'b0;
              ctl_lo_next[CTL_UF]  = ctl_lo[CTL_UF] & write_data[CTL_UF];
              if (write_data[CTL_TRG] || write_data[CTL_CNTE]) begin
                cnt_next = reload;
                pre_next = '0;
              end
              run_next = write_data[CTL_CNTE];
            end
            REG_CTL_HI: ctl_hi_next = write_data;
            REG_RLD_LO: rld_lo_next = write_data;
            REG_RLD_HI: rld_hi_next = write_data;
          endcase
        end
      end
      CMD_TICK: begin
        if (csl != CSL_EVENT && counting) begin
          if (pre_hit) begin
            pre_next = '0;
            dec      = 1'b1;
          end else begin
            pre_next = pre_inc;
          end
        end
      end
      CMD_SAMPLE: begin
        last_next = pin;
        if (csl == CSL_EVENT && counting && edge_hit) begin
          dec = 1'b1;
        end
      end
    endcase

    // Count down; on underflow set UF and reload or stop
    if (dec) begin
      if (cnt == '0) begin
        uf = 1'b1;
        ctl_lo_next[CTL_UF] = 1'b1;
        if (ctl_lo[CTL_RELD]) begin
          cnt_next = reload;
        end else begin
          cnt_next = '1;
          run_next = 1'b0;
        end
      end else begin
        cnt_next = cnt - 16'd1;
      end
    end
  end

  // Register byte seen by a read
  always_comb begin
    unique case (reg_idx)
      REG_CTL_LO: rd_byte = ctl_lo;
      REG_CTL_HI: rd_byte = ctl_hi;
      REG_RLD_LO: rd_byte = rld_lo;
      REG_RLD_HI: rd_byte = rld_hi;
    endcase
  end

  assign status.irq    = ctl_lo_next[CTL_UF] & ctl_lo_next[CTL_INTE];
  assign status.uf_now = uf;

  // Commit state when the request is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_lo <= '0;
      ctl_hi <= '0;
      rld_lo <= '0;
      rld_hi <= '0;
      cnt    <= '0;
      pre    <= '0;
      run    <= 1'b0;
      last   <= 1'b0;
    end else if (step) begin
      ctl_lo <= ctl_lo_next;
      ctl_hi <= ctl_hi_next;
      rld_lo <= rld_lo_next;
      rld_hi <= rld_hi_next;
      cnt    <= cnt_next;
      pre    <= pre_next;
      run    <= run_next;
      last   <= last_next;
    end
  end

endmodule : drt_timer
`default_nettype wire

### sv/dual_reload_timer_event_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_reload_timer_event_counter: two 16-bit reload timers with event count
//
// Usage:
//   A request enters on in_valid/in_ready: a register read or write
//   (reg_offset, write_data), a machine clock tick, or a sample of the two
//   event pins (pin_levels). Each request returns exactly one result on
//   out_valid/out_ready: read_data (zero unless a read), the interrupt
//   request levels after the request, and the per-timer underflow flags.
//   A request is held in the input register; the timer update and the
//   result register load happen at the same edge. One request is accepted every
//   cycle; in_ready only drops while the result register is full, the
//   input register is loaded and out_ready is low.
//   When the receiver stalls, the result holds and one more request waits
//   in the input register; no request is lost or processed twice.
//   Reset clears all register bytes, counters, prescalers, run flags and
//   pin history, and empties both pipeline registers.
// ----------------------------------------------------------------------------
module dual_reload_timer_event_counter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic [2:0]                        reg_offset,
  input  wire logic [7:0]                        write_data,
  input  wire logic [drt_pkg::TIMER_SLOTS-1:0]   pin_levels,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             read_data,
  output logic [drt_pkg::TIMER_SLOTS-1:0]        irq_requests,
  output logic [drt_pkg::TIMER_SLOTS-1:0]        underflow_now
);
  import drt_pkg::*;

  // Input register
  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic [2:0]             s1_off;
  logic [7:0]             s1_data;
  logic [TIMER_SLOTS-1:0] s1_pins;

  logic                   adv;
  logic [7:0]             rd_bytes [TIMER_SLOTS];
  timer_status_t          stat [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] irq_next;
  logic [TIMER_SLOTS-1:0] uf_next;
  logic [7:0]             read_data_next;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Capture an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= cmd_t'(command);
      s1_off  <= reg_offset;
      s1_data <= write_data;
      s1_pins <= pin_levels;
    end
  end

  // Timer slices; absent timers read as zero and never fire
  for (genvar t = 0; t < TIMER_SLOTS; t++) begin : g_timer
    if (t < NUM_TIMERS) begin : g_present
      drt_timer u_timer (
        .clk        (clk),
        .rst        (rst),
        .step       (adv),
        .cmd        (s1_cmd),
        .sel        (s1_off[2] == 1'(t)),
        .reg_idx    (reg_sel_t'(s1_off[1:0])),
        .write_data (s1_data),
        .pin        (s1_pins[t]),
        .rd_byte    (rd_bytes[t]),
        .status     (stat[t])
      );
    end else begin : g_absent
      assign rd_bytes[t] = '0;
      assign stat[t]     = '0;
    end
    assign irq_next[t] = stat[t].irq;
    assign uf_next[t]  = stat[t].uf_now;
  end

  assign read_data_next = (s1_cmd == CMD_READ) ? rd_bytes[s1_off[2]] : 8'h00;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data     <= read_data_next;
      irq_requests  <= irq_next;
      underflow_now <= uf_next;
    end
  end

  // An empty result register never blocks intake
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Only a read returns register data
  a_read_only_data : assert property (@(posedge clk) disable iff (rst)
    (adv && s1_cmd != CMD_READ) |=> read_data == 8'h00)
    else $error("nonzero read_data on a non-read request");

  // Register accesses never count a timer down
  a_no_uf_on_access : assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_cmd == CMD_READ || s1_cmd == CMD_WRITE)) |=> underflow_now == '0)
    else $error("underflow reported on a register access");

endmodule : dual_reload_timer_event_counter
`default_nettype wire
